/* rtl/fmbq_pkg.sv */
`default_nettype none
package fmbq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int STATUS_W = 2;
  localparam int OCC_W = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_MIDDLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_POP_MIDDLE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_POP_BACK    = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     pop_tap;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/fmbq_cell.sv */
`default_nettype none
module fmbq_cell (
  input  wire logic              clk,
  input  wire fmbq_pkg::cell_ctl_t ctl,
  input  wire fmbq_pkg::data_t   left,
  input  wire fmbq_pkg::data_t   right,
  input  wire fmbq_pkg::data_t   load,
  output fmbq_pkg::data_t        data,
  output fmbq_pkg::data_t        pop_data
);
  import fmbq_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_FROM_LEFT:  data <= left;
      CELL_FROM_RIGHT: data <= right;
      CELL_LOAD:       data <= load;
      default:         data <= data;
    endcase
  end

  // only the cell being removed contributes to the popped value
  assign pop_data = ctl.pop_tap ? data : '0;

endmodule
`default_nettype wire

/* rtl/front_middle_back_queue.sv */
// an accepted result is registered as pending, then in the output register
// one item per cycle unless stalled, every cell shifts or holds in parallel
// the output register holds a stalled result while the next item is applied
// reset: synchronous, clears the element count and both valid flags
// cell contents are left as they are and only indices below the count are read
`default_nettype none
module front_middle_back_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [fmbq_pkg::KIND_W-1:0]    kind,
  input  wire fmbq_pkg::data_t                value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [fmbq_pkg::STATUS_W-1:0]       status,
  output fmbq_pkg::data_t                     popped_value,
  output fmbq_pkg::data_t                     front_value,
  output fmbq_pkg::data_t                     middle_value,
  output fmbq_pkg::data_t                     back_value,
  output logic [fmbq_pkg::OCC_W-1:0]          occupancy
);
  import fmbq_pkg::*;

  cell_ctl_t ctl [CAPACITY];
  data_t     cell_data [CAPACITY];
  data_t     cell_pop [CAPACITY];

  count_t                count;
  count_t                count_next;
  logic                  pend;
  logic [STATUS_W-1:0]   pend_status;
  data_t                 pend_popped;

  logic                  accept;
  logic                  out_free;
  logic                  pend_take;
  logic                  is_push;
  logic                  is_pop;
  logic                  push_ok;
  logic                  pop_ok;
  count_t                pos;
  logic [STATUS_W-1:0]   step_status;
  data_t                 popped_sel;
  count_t                mid_idx;
  count_t                back_idx;
  data_t                 front_sel;
  data_t                 mid_sel;
  data_t                 back_sel;

  assign out_free  = !out_valid || !out_stall;
  assign pend_take = pend && out_free;
  assign in_stall  = pend && !out_free;
  assign accept    = in_valid && !in_stall;

  // decode the operation and the position it acts on
  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    pos     = '0;
    unique case (kind) inside
      KIND_PUSH_FRONT, KIND_PUSH_MIDDLE, KIND_PUSH_BACK: is_push = 1'b1;
      KIND_POP_FRONT, KIND_POP_MIDDLE, KIND_POP_BACK:    is_pop  = 1'b1;
      default: begin
        is_push = 1'b0;
        is_pop  = 1'b0;
      end
    endcase
    unique case (kind)
      KIND_PUSH_MIDDLE: pos = count_t'((count + count_t'(1)) >> 1);
      KIND_PUSH_BACK:   pos = count;
      KIND_POP_MIDDLE:  pos = count_t'((count - count_t'(1)) >> 1);
      KIND_POP_BACK:    pos = count - count_t'(1);
      default:          pos = '0;
    endcase
    push_ok = accept && is_push && (count < count_t'(CAPACITY));
    pop_ok  = accept && is_pop && (count != '0);
    if (is_push && !(count < count_t'(CAPACITY))) begin
      step_status = STATUS_FULL;
    end else if (is_pop && count == '0) begin
      step_status = STATUS_EMPTY;
    end else begin
      step_status = STATUS_DONE;
    end
    count_next = count;
    if (push_ok) begin
      count_next = count + count_t'(1);
    end else if (pop_ok) begin
      count_next = count - count_t'(1);
    end
  end

  // push loads at pos and shifts cells past it, pop shifts from pos, the rest hold
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl[i].op      = CELL_HOLD;
      ctl[i].pop_tap = (count_t'(i) == pos);
      if (push_ok) begin
        if (count_t'(i) > pos) begin
          ctl[i].op = CELL_FROM_LEFT;
        end else if (count_t'(i) == pos) begin
          ctl[i].op = CELL_LOAD;
        end
      end else if (pop_ok) begin
        if (count_t'(i) >= pos) begin
          ctl[i].op = CELL_FROM_RIGHT;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_in;
    data_t right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_data[g+1];
    end
    fmbq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[g]),
      .left     (left_in),
      .right    (right_in),
      .load     (value),
      .data     (cell_data[g]),
      .pop_data (cell_pop[g])
    );
  end

  always_comb begin
    popped_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      popped_sel = popped_sel | cell_pop[i];
    end
  end

  // taps on the contents after the step, read when the pending result is taken
  assign mid_idx  = count_t'((count - count_t'(1)) >> 1);
  assign back_idx = count - count_t'(1);

  always_comb begin
    front_sel = '0;
    mid_sel   = '0;
    back_sel  = '0;
    if (count != '0) begin
      front_sel = cell_data[0];
      for (int i = 0; i < CAPACITY; i++) begin
        if (count_t'(i) == mid_idx) begin
          mid_sel = mid_sel | cell_data[i];
        end
        if (count_t'(i) == back_idx) begin
          back_sel = back_sel | cell_data[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        pend <= 1'b1;
      end else if (pend_take) begin
        pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= step_status;
      pend_popped <= pop_ok ? popped_sel : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      status       <= pend_status;
      popped_value <= pend_popped;
      front_value  <= front_sel;
      middle_value <= mid_sel;
      back_value   <= back_sel;
      occupancy    <= OCC_W'(count);
    end
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import fmbq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam data_t DATA_MIN = 32'sh8000_0000;
  localparam data_t DATA_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_PER_PHASE = 130;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    data_t               popped;
    data_t               front;
    data_t               middle;
    data_t               back;
    logic [OCC_W-1:0]    occ;
  } queue_view_t;

  typedef struct {
    logic [KIND_W-1:0] k;
    data_t             v;
    bit                pinned;
    queue_view_t       view;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   kind;
  data_t               value;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] status;
  data_t               popped_value;
  data_t               front_value;
  data_t               middle_value;
  data_t               back_value;
  logic [OCC_W-1:0]    occupancy;

  data_t       seq_elems[$];
  queue_view_t pending_views[$];
  plan_row_t   opening_plan[$];
  int          bad_results = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          idle_by_phase[4] = '{0, 78, 0, 24};
  int          stall_by_phase[4] = '{0, 0, 78, 24};

  front_middle_back_queue dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .popped_value(popped_value),
    .front_value(front_value),
    .middle_value(middle_value),
    .back_value(back_value),
    .occupancy(occupancy)
  );

  always #1 clk = ~clk;

  // applies one operation to the sequence and returns what the block should report
  function automatic queue_view_t step_sequence(logic [KIND_W-1:0] k, data_t v);
    queue_view_t r;
    int          n;
    int          idx;
    r = '0;
    r.status = STATUS_DONE;
    n = seq_elems.size();
    case (k)
      KIND_PUSH_FRONT, KIND_PUSH_MIDDLE, KIND_PUSH_BACK: begin
        if (n >= CAPACITY) begin
          r.status = STATUS_FULL;
        end else if (k == KIND_PUSH_FRONT) begin
          seq_elems.insert(0, v);
        end else if (k == KIND_PUSH_MIDDLE) begin
          seq_elems.insert((n + 1) / 2, v);
        end else begin
          seq_elems.insert(n, v);
        end
      end
      KIND_POP_FRONT, KIND_POP_MIDDLE, KIND_POP_BACK: begin
        if (n == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          if (k == KIND_POP_FRONT) idx = 0;
          else if (k == KIND_POP_MIDDLE) idx = (n - 1) / 2;
          else idx = n - 1;
          r.popped = seq_elems[idx];
          seq_elems.delete(idx);
        end
      end
      default: ;
    endcase
    n = seq_elems.size();
    if (n > 0) begin
      r.front = seq_elems[0];
      r.middle = seq_elems[(n - 1) / 2];
      r.back = seq_elems[n - 1];
    end
    r.occ = n[OCC_W-1:0];
    return r;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return DATA_MIN;
      1: return DATA_MAX;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_step(logic [KIND_W-1:0] k, data_t v);
    plan_row_t row;
    row.k = k;
    row.v = v;
    row.pinned = 1'b0;
    row.view = '0;
    opening_plan.insert(opening_plan.size(), row);
  endfunction

  function automatic void add_pinned(logic [KIND_W-1:0] k, data_t v,
                                     logic [STATUS_W-1:0] st, data_t pop, data_t fr,
                                     data_t mid, data_t bk, logic [OCC_W-1:0] occ);
    plan_row_t row;
    row.k = k;
    row.v = v;
    row.pinned = 1'b1;
    row.view.status = st;
    row.view.popped = pop;
    row.view.front = fr;
    row.view.middle = mid;
    row.view.back = bk;
    row.view.occ = occ;
    opening_plan.insert(opening_plan.size(), row);
  endfunction

  // presents one operation, holds it until the transfer, then records what should come back
  task automatic issue_op(input logic [KIND_W-1:0] k, input data_t v,
                          input bit pinned, input queue_view_t view);
    queue_view_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = step_sequence(k, v);
    pending_views.insert(pending_views.size(), pinned ? view : predicted);
  endtask

  always @(posedge clk) begin
    if (stall_pct == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    queue_view_t seen;
    queue_view_t want;
    if (!rst && out_valid && !out_stall) begin
      seen.status = status;
      seen.popped = popped_value;
      seen.front = front_value;
      seen.middle = middle_value;
      seen.back = back_value;
      seen.occ = occupancy;
      if (pending_views.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: st=%0d pop=%h front=%h mid=%h back=%h occ=%0d",
                   seen.status, seen.popped, seen.front, seen.middle, seen.back, seen.occ);
      end else begin
        want = pending_views[0];
        pending_views.delete(0);
        if (seen !== want) begin
          bad_results++;
          if (bad_results <= 10)
            $display({"mismatch: expected st=%0d pop=%h front=%h mid=%h back=%h occ=%0d,",
                      " got st=%0d pop=%h front=%h mid=%h back=%h occ=%0d"},
                     want.status, want.popped, want.front, want.middle, want.back, want.occ,
                     seen.status, seen.popped, seen.front, seen.middle, seen.back, seen.occ);
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("front_middle_back_queue test failed");
    $finish;
  end

  initial begin
    int          sent;
    int          extra;
    int          run_len;
    int          r;
    logic [KIND_W-1:0] k;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    value = '0;
    out_stall = 1'b0;

    // empty: every pop is refused, unused kinds report zeros; then two pushes, one back pop
    add_pinned(KIND_POP_FRONT, DATA_MAX, STATUS_EMPTY, 0, 0, 0, 0, 0);
    add_pinned(KIND_POP_MIDDLE, DATA_MIN, STATUS_EMPTY, 0, 0, 0, 0, 0);
    add_pinned(KIND_POP_BACK, -1, STATUS_EMPTY, 0, 0, 0, 0, 0);
    add_pinned(KIND_UNUSED_LO, DATA_MAX, STATUS_DONE, 0, 0, 0, 0, 0);
    add_pinned(KIND_PUSH_FRONT, DATA_MIN, STATUS_DONE, 0, DATA_MIN, DATA_MIN, DATA_MIN, 1);
    add_pinned(KIND_PUSH_MIDDLE, DATA_MAX, STATUS_DONE, 0, DATA_MIN, DATA_MIN, DATA_MAX, 2);
    add_pinned(KIND_POP_BACK, 0, STATUS_DONE, DATA_MAX, DATA_MIN, DATA_MIN, DATA_MIN, 1);
    // middle pop of a single element
    add_pinned(KIND_POP_MIDDLE, 0, STATUS_DONE, DATA_MIN, 0, 0, 0, 0);
    for (int i = 0; i < CAPACITY; i++) begin
      if (i % 3 == 0) k = KIND_PUSH_BACK;
      else if (i % 3 == 1) k = KIND_PUSH_MIDDLE;
      else k = KIND_PUSH_FRONT;
      add_step(k, data_t'(32'h0101_0101 * (i + 1)) ^ ((i % 2) ? DATA_MIN : '0));
    end
    add_step(KIND_PUSH_MIDDLE, 32'sh1234_5678);
    add_step(KIND_UNUSED_HI, -1);
    add_step(KIND_POP_MIDDLE, 0);
    add_step(KIND_POP_FRONT, 0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0) begin
        foreach (opening_plan[i])
          issue_op(opening_plan[i].k, opening_plan[i].v, opening_plan[i].pinned,
                   opening_plan[i].view);
      end
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        r = $urandom_range(99);
        if (r < 10) begin
          // fill up, then knock on the full sequence
          while (seq_elems.size() < CAPACITY) begin
            issue_op(KIND_W'(KIND_PUSH_FRONT + $urandom_range(2)), pick_value(), 1'b0, '0);
            sent++;
          end
          extra = $urandom_range(1, 3);
          repeat (extra)
            issue_op(KIND_W'(KIND_PUSH_FRONT + $urandom_range(2)), pick_value(), 1'b0, '0);
          sent += extra;
        end else if (r < 20) begin
          // drain to empty, then pop once or twice more
          while (seq_elems.size() > 0) begin
            issue_op(KIND_W'(KIND_POP_FRONT + $urandom_range(2)), pick_value(), 1'b0, '0);
            sent++;
          end
          extra = $urandom_range(1, 2);
          repeat (extra)
            issue_op(KIND_W'(KIND_POP_FRONT + $urandom_range(2)), pick_value(), 1'b0, '0);
          sent += extra;
        end else begin
          run_len = $urandom_range(1, 8);
          repeat (run_len) begin
            r = $urandom_range(99);
            if (r < 4) begin
              issue_op($urandom_range(1) ? KIND_UNUSED_HI : KIND_UNUSED_LO, pick_value(),
                       1'b0, '0);
            end else begin
              if (r < 52) k = KIND_W'(KIND_PUSH_FRONT + $urandom_range(2));
              else k = KIND_W'(KIND_POP_FRONT + $urandom_range(2));
              issue_op(k, pick_value(), 1'b0, '0);
              sent++;
            end
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_results == 0) begin
      $display("front_middle_back_queue test passed");
    end else begin
      $display("front_middle_back_queue test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/fmbq_pkg.sv
rtl/fmbq_cell.sv
rtl/front_middle_back_queue.sv
tb/tb_top.sv
